@@ src/gradient_fill_color_defines.svh @@
// assertion helpers used by the checker module
`ifndef GRADIENT_FILL_COLOR_DEFINES_SVH
`define GRADIENT_FILL_COLOR_DEFINES_SVH

// same-cycle implication, sampled on clk
`define GFC_ASSERT_NOW(label, cond, expr) \
  label: assert property (@(posedge clk) (cond) |-> (expr)) \
    else $error("gradient fill color check failed");

// next-cycle implication, sampled on clk
`define GFC_ASSERT_NEXT(label, cond, expr) \
  label: assert property (@(posedge clk) (cond) |=> (expr)) \
    else $error("gradient fill color check failed");

`endif

@@ src/gfc_pkg.sv @@
`default_nettype none

package gfc_pkg;

  localparam int MAX_STOPS = 16;
  localparam int SLOT_W    = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
  localparam int STOP_W    = 40;
  localparam int POS_W     = 17;
  localparam logic [POS_W-1:0] POS_ONE = 17'd65536;
  localparam int PADDR_W   = 4;

  localparam logic [1:0] MODE_LINEAR = 2'd0;
  localparam logic [1:0] MODE_RADIAL = 2'd1;
  localparam logic [1:0] MODE_FOCAL  = 2'd2;
  localparam logic [1:0] MODE_NONE   = 2'd3;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic [1:0] REG_FILL_MODE    = 2'd0;
  localparam logic [1:0] REG_FOCAL_OFFSET = 2'd1;
  localparam logic [1:0] REG_STOP_COUNT   = 2'd2;

  typedef struct packed {
    logic               kind;
    logic [3:0]         stop_slot;
    logic [7:0]         stop_ratio;
    logic [31:0]        stop_color;
    logic signed [23:0] point_x;
    logic signed [23:0] point_y;
  } item_t;

  typedef struct packed {
    logic               valid;
    logic               is_query;
    item_t              item;
  } front_out_t;

  typedef struct packed {
    logic [1:0]         fill_mode;
    logic signed [9:0]  focal_offset;
    logic [4:0]         stop_count;
  } cfg_t;

endpackage

`default_nettype wire

@@ src/gfc_ram.sv @@
`default_nettype none

module gfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]               wdata,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]               rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ src/gfc_front.sv @@
`default_nettype none

module gfc_front import gfc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  item_t      in_item,
  input  logic       take,
  output front_out_t head
);

  // two-entry queue toward the back end
  item_t      slots [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full    = (count == 2'd2);
  assign do_push = push && !full;
  assign do_pop  = take && (count != 2'd0);

  always_comb begin
    head.valid    = (count != 2'd0);
    head.item     = slots[rp];
    head.is_query = (slots[rp].kind == KIND_QUERY);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wp] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) wp <= ~wp;
      if (do_pop)  rp <= ~rp;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

`default_nettype wire

@@ src/gfc_back.sv @@
`default_nettype none

module gfc_back import gfc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  front_out_t  head,
  output logic        take,
  input  logic        pop,
  output logic        out_valid,
  output logic [31:0] out_color
);

  localparam logic [4:0] ST_IDLE     = 5'd0;
  localparam logic [4:0] ST_RAD_X    = 5'd1;
  localparam logic [4:0] ST_RAD_Y    = 5'd2;
  localparam logic [4:0] ST_FOC_CHK  = 5'd3;
  localparam logic [4:0] ST_FOC_A    = 5'd4;
  localparam logic [4:0] ST_FOC_B    = 5'd5;
  localparam logic [4:0] ST_FOC_C    = 5'd6;
  localparam logic [4:0] ST_FOC_D    = 5'd7;
  localparam logic [4:0] ST_SQRT     = 5'd8;
  localparam logic [4:0] ST_FOC_FDX  = 5'd9;
  localparam logic [4:0] ST_FOC_E    = 5'd10;
  localparam logic [4:0] ST_DIV      = 5'd11;
  localparam logic [4:0] ST_SCAN_RD  = 5'd12;
  localparam logic [4:0] ST_SCAN_CHK = 5'd13;
  localparam logic [4:0] ST_PREP     = 5'd14;
  localparam logic [4:0] ST_CH       = 5'd15;
  localparam logic [4:0] ST_OUT      = 5'd16;

  logic [4:0]        state;
  logic [POS_W-1:0]  pos;
  logic [SLOT_W-1:0] idx;
  logic [SLOT_W-1:0] last_idx;
  logic [23:0]       xa;
  logic [23:0]       ya;
  logic [23:0]       ydy;
  logic signed [9:0] fc;
  logic signed [25:0] dx;
  logic [47:0]       acc;
  logic [31:0]       fdy;
  logic signed [32:0] fdx;
  logic [63:0]       sq_n;
  logic [63:0]       sq_res;
  logic [63:0]       sq_bit;
  logic              is_focal;
  logic [51:0]       rem;
  logic [51:0]       dd;
  logic [15:0]       q;
  logic [4:0]        div_cnt;
  logic [31:0]       lcol;
  logic [31:0]       rcol;
  logic [7:0]        lr;
  logic [7:0]        rr;
  logic [23:0]       num;
  logic [23:0]       den;
  logic [1:0]        ch;
  logic [31:0]       color;

  // stop table
  logic              ram_we;
  logic [STOP_W-1:0] rdata;

  assign take   = (state == ST_IDLE);
  assign ram_we = take && head.valid && !head.is_query &&
                  (32'(head.item.stop_slot) < MAX_STOPS);

  gfc_ram #(.WIDTH(STOP_W), .DEPTH(MAX_STOPS)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (SLOT_W'(head.item.stop_slot)),
    .wdata ({head.item.stop_ratio, head.item.stop_color}),
    .raddr (idx),
    .rdata (rdata)
  );

  // shared multiplier
  logic [9:0]  fc_mag;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;

  assign fc_mag = fc[9] ? 10'(-fc) : 10'(fc);

  always_comb begin
    unique case (state)
      ST_RAD_X, ST_FOC_A: begin mul_a = 32'(xa); mul_b = 32'(xa); end
      ST_RAD_Y, ST_FOC_B: begin mul_a = 32'(ya); mul_b = 32'(ya); end
      ST_FOC_C:           begin mul_a = 32'(fc_mag); mul_b = 32'(ya); end
      ST_FOC_D:           begin mul_a = fdy; mul_b = fdy; end
      ST_FOC_FDX:         begin mul_a = 32'(fc_mag); mul_b = 32'(xa); end
      default:            begin mul_a = 32'd0; mul_b = 32'd0; end
    endcase
  end

  assign prod = 64'(mul_a) * 64'(mul_b);

  // front-of-query position terms
  logic signed [25:0] x26;
  logic signed [25:0] lin_t;
  logic [POS_W-1:0]   lin_pos;
  logic signed [9:0]  fc_next;
  logic signed [25:0] dx_next;
  logic [23:0]        x_mag;
  logic [23:0]        y_mag;
  logic [SLOT_W-1:0]  last_next;

  assign x26   = {{2{head.item.point_x[23]}}, head.item.point_x};
  assign lin_t = x26 + 26'sd4194304;
  assign x_mag = head.item.point_x[23] ? 24'(-head.item.point_x) : head.item.point_x;
  assign y_mag = head.item.point_y[23] ? 24'(-head.item.point_y) : head.item.point_y;

  always_comb begin
    if (lin_t[25] || (lin_t == 26'sd0)) begin
      lin_pos = '0;
    end else if (lin_t[25:7] > 19'(POS_ONE)) begin
      lin_pos = POS_ONE;
    end else begin
      lin_pos = lin_t[23:7];
    end
  end

  always_comb begin
    if (cfg.focal_offset > 10'sd256) begin
      fc_next = 10'sd256;
    end else if (cfg.focal_offset < -10'sd256) begin
      fc_next = -10'sd256;
    end else begin
      fc_next = cfg.focal_offset;
    end
  end

  assign dx_next = x26 - {{2{fc_next[9]}}, fc_next, 14'b0};

  always_comb begin
    if (cfg.stop_count == 5'd0) begin
      last_next = '0;
    end else if (32'(cfg.stop_count) > MAX_STOPS) begin
      last_next = SLOT_W'(MAX_STOPS - 1);
    end else begin
      last_next = SLOT_W'(cfg.stop_count - 5'd1);
    end
  end

  // focal checks
  logic        dx_big;
  logic        dy_big;
  logic        ray_zero;
  logic [25:0] dx_mag;
  logic [23:0] dy_mag;

  assign dx_big   = (dx >= 26'sd8388608) || (dx <= -26'sd8388608);
  assign dy_big   = (ydy == 24'h800000);
  assign ray_zero = (dx == 26'sd0) && (ydy == 24'd0);
  assign dx_mag   = dx[25] ? 26'(-dx) : 26'(dx);
  assign dy_mag   = ydy[23] ? 24'(-ydy) : ydy;

  // square root step
  logic [63:0] sq_sum;
  logic        sq_ge;
  logic [63:0] sq_next;

  assign sq_sum  = sq_res + sq_bit;
  assign sq_ge   = (sq_n >= sq_sum);
  assign sq_next = sq_ge ? (sq_res >> 1) + sq_bit : sq_res >> 1;

  // focal denominator
  logic signed [34:0] dsum;
  logic [51:0]        four_a;
  logic [51:0]        d_sh;
  logic               foc_one;

  assign dsum    = $signed({2'b0, sq_res[32:0]}) - $signed({{2{fdx[32]}}, fdx});
  assign four_a  = {2'b0, acc, 2'b0};
  assign d_sh    = {1'b0, dsum, 16'b0};
  assign foc_one = dsum[34] || (dsum == 35'sd0) || (four_a >= d_sh);

  // divider step
  logic        div_ge;
  logic [15:0] q_new;

  assign div_ge = (rem >= dd);
  assign q_new  = {q[14:0], div_ge};

  // stop search and interpolation
  logic [24:0] p255;
  logic [7:0]  e_ratio;
  logic [31:0] e_col;
  logic        e_lt;
  logic [24:0] lr16;
  logic        degen;
  logic [24:0] num_raw;
  logic [23:0] den_raw;
  logic [7:0]  lb;
  logic [7:0]  rb;
  logic [32:0] dvd;

  assign p255    = {pos, 8'b0} - {8'b0, pos};
  assign e_ratio = rdata[39:32];
  assign e_col   = rdata[31:0];
  assign e_lt    = (p255 < {1'b0, e_ratio, 16'b0});
  assign lr16    = {1'b0, lr, 16'b0};
  assign degen   = (rr <= lr) || (p255 < lr16);
  assign num_raw = p255 - lr16;
  assign den_raw = {8'(rr - lr), 16'b0};
  assign lb      = lcol[8*ch +: 8];
  assign rb      = rcol[8*ch +: 8];
  assign dvd     = 33'(lb) * 33'(den - num) + 33'(rb) * 33'(num) + 33'(den >> 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (pop && out_valid && (state != ST_OUT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (head.valid && head.is_query) begin
            last_idx <= last_next;
            idx      <= '0;
            lr       <= 8'd0;
            rr       <= 8'd255;
            fc       <= fc_next;
            dx       <= dx_next;
            ydy      <= head.item.point_y;
            xa       <= x_mag;
            ya       <= y_mag;
            unique case (cfg.fill_mode)
              MODE_LINEAR: begin pos <= lin_pos; state <= ST_SCAN_RD; end
              MODE_RADIAL: state <= ST_RAD_X;
              MODE_FOCAL:  state <= ST_FOC_CHK;
              MODE_NONE:   begin pos <= '0; state <= ST_SCAN_RD; end
            endcase
          end
        end
        ST_RAD_X: begin
          acc   <= prod[47:0];
          state <= ST_RAD_Y;
        end
        ST_RAD_Y: begin
          sq_n     <= {16'b0, acc + prod[47:0]} >> 12;
          sq_res   <= '0;
          sq_bit   <= 64'd1 << 62;
          is_focal <= 1'b0;
          state    <= ST_SQRT;
        end
        ST_FOC_CHK: begin
          xa <= dx_mag[23:0];
          ya <= dy_mag;
          priority if (ray_zero) begin
            pos   <= '0;
            state <= ST_SCAN_RD;
          end else if (dx_big || dy_big) begin
            pos   <= POS_ONE;
            state <= ST_SCAN_RD;
          end else begin
            state <= ST_FOC_A;
          end
        end
        ST_FOC_A: begin
          acc   <= prod[47:0];
          state <= ST_FOC_B;
        end
        ST_FOC_B: begin
          acc   <= acc + prod[47:0];
          state <= ST_FOC_C;
        end
        ST_FOC_C: begin
          fdy   <= prod[31:0];
          state <= ST_FOC_D;
        end
        ST_FOC_D: begin
          sq_n     <= {acc[47:0], 16'b0} - prod;
          sq_res   <= '0;
          sq_bit   <= 64'd1 << 62;
          is_focal <= 1'b1;
          state    <= ST_SQRT;
        end
        ST_SQRT: begin
          if (sq_ge) begin
            sq_n <= sq_n - sq_sum;
          end
          sq_res <= sq_next;
          sq_bit <= sq_bit >> 2;
          if (sq_bit == 64'd1) begin
            if (is_focal) begin
              state <= ST_FOC_FDX;
            end else begin
              // radial position is the radius, clamped to 1.0
              pos   <= (sq_next > 64'(POS_ONE)) ? POS_ONE : sq_next[POS_W-1:0];
              state <= ST_SCAN_RD;
            end
          end
        end
        ST_FOC_FDX: begin
          fdx   <= (fc[9] ^ dx[25]) ? -$signed({1'b0, prod[31:0]})
                                    : $signed({1'b0, prod[31:0]});
          state <= ST_FOC_E;
        end
        ST_FOC_E: begin
          if (foc_one) begin
            pos   <= POS_ONE;
            state <= ST_SCAN_RD;
          end else begin
            rem     <= four_a;
            dd      <= d_sh >> 1;
            q       <= '0;
            div_cnt <= 5'd16;
            state   <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_ge) begin
            rem <= rem - dd;
          end
          dd      <= dd >> 1;
          q       <= q_new;
          div_cnt <= div_cnt - 5'd1;
          if (div_cnt == 5'd1) begin
            if (is_focal) begin
              pos   <= {1'b0, q_new};
              state <= ST_SCAN_RD;
            end else begin
              color[8*ch +: 8] <= q_new[7:0];
              ch               <= ch + 2'd1;
              state            <= (ch == 2'd3) ? ST_OUT : ST_CH;
            end
          end
        end
        ST_SCAN_RD: begin
          state <= ST_SCAN_CHK;
        end
        ST_SCAN_CHK: begin
          if (idx == '0 && e_lt) begin
            lcol <= e_col;
          end
          if (e_lt) begin
            rcol  <= e_col;
            rr    <= e_ratio;
            state <= ST_PREP;
          end else begin
            lcol <= e_col;
            lr   <= e_ratio;
            if (idx == last_idx) begin
              rcol  <= e_col;
              rr    <= 8'd255;
              state <= ST_PREP;
            end else begin
              idx   <= idx + 1'b1;
              state <= ST_SCAN_RD;
            end
          end
        end
        ST_PREP: begin
          if (degen) begin
            num <= 24'd0;
            den <= 24'd1;
          end else begin
            den <= den_raw;
            num <= (num_raw > {1'b0, den_raw}) ? den_raw : num_raw[23:0];
          end
          ch       <= 2'd0;
          is_focal <= 1'b0;
          state    <= ST_CH;
        end
        ST_CH: begin
          rem     <= 52'(dvd);
          dd      <= 52'(den) << 7;
          q       <= '0;
          div_cnt <= 5'd8;
          state   <= ST_DIV;
        end
        ST_OUT: begin
          if (!out_valid || pop) begin
            out_valid <= 1'b1;
            out_color <= color;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ src/gradient_fill_color.sv @@
// gradient fill color: load items write the stop table from idle, one result per query
// query path: linear and none go straight to the stop scan; radial adds a 32-step square
//   root; focal adds a square root and a divide, both skipped for a zero ray or far point
//   and the divide skipped when the position saturates; a result waits until popped
// throughput: one item at a time in the back end; two items can wait in the input queue
// reset (rst, synchronous): queues empty, fill_mode 0, focal_offset 0, stop_count 1
`default_nettype none

module gradient_fill_color import gfc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // input queue side
  input  logic               push,
  output logic               full,
  input  logic               kind,
  input  logic [3:0]         stop_slot,
  input  logic [7:0]         stop_ratio,
  input  logic [31:0]        stop_color,
  input  logic signed [23:0] point_x,
  input  logic signed [23:0] point_y,
  // result queue side
  output logic               empty,
  input  logic               pop,
  output logic [7:0]         red,
  output logic [7:0]         green,
  output logic [7:0]         blue,
  output logic [7:0]         alpha,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // configuration registers; the user writes them only while the block is idle (not enforced)
  cfg_t        cfg;
  logic        cfg_wr;
  logic [1:0]  reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fill_mode    <= MODE_LINEAR;
      cfg.focal_offset <= 10'sd0;
      cfg.stop_count   <= 5'd1;
    end else if (cfg_wr) begin
      // writes past the last register are dropped
      unique case (reg_sel)
        REG_FILL_MODE:    cfg.fill_mode    <= pwdata[1:0];
        REG_FOCAL_OFFSET: cfg.focal_offset <= pwdata[9:0];
        REG_STOP_COUNT:   cfg.stop_count   <= pwdata[4:0];
        default:          ;
      endcase
    end
  end

  // read back; focal offset sign-extended
  always_comb begin
    unique case (reg_sel)
      REG_FILL_MODE:    prdata = {30'b0, cfg.fill_mode};
      REG_FOCAL_OFFSET: prdata = {{22{cfg.focal_offset[9]}}, cfg.focal_offset};
      REG_STOP_COUNT:   prdata = {27'b0, cfg.stop_count};
      default:          prdata = 32'd0;
    endcase
  end

  // front end: short queue that takes a transfer whenever it has room,
  // also while the back end is busy or a result is waiting
  item_t      in_item;
  front_out_t head;
  logic       take;

  always_comb begin
    in_item.kind       = kind;
    in_item.stop_slot  = stop_slot;
    in_item.stop_ratio = stop_ratio;
    in_item.stop_color = stop_color;
    in_item.point_x    = point_x;
    in_item.point_y    = point_y;
  end

  gfc_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .in_item (in_item),
    .take    (take),
    .head    (head)
  );

  // back end: stop loads, position math, stop search, channel blend
  logic        out_valid;
  logic [31:0] out_color;

  gfc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .head      (head),
    .take      (take),
    .pop       (pop && out_valid),
    .out_valid (out_valid),
    .out_color (out_color)
  );

  // result register is the output side of the queue
  assign empty = !out_valid;
  assign red   = out_color[7:0];
  assign green = out_color[15:8];
  assign blue  = out_color[23:16];
  assign alpha = out_color[31:24];

endmodule

`default_nettype wire

@@ src/gfc_checker.sv @@
`default_nettype none
`include "gradient_fill_color_defines.svh"

module gfc_checker import gfc_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input logic [7:0]         red,
  input logic [7:0]         green,
  input logic [7:0]         blue,
  input logic [7:0]         alpha,
  input logic               psel,
  input logic               pwrite,
  input logic [PADDR_W-1:0] paddr,
  input logic [31:0]        prdata,
  input logic               pready
);

  `GFC_ASSERT_NOW(a_pready_high, 1'b1, pready)
  `GFC_ASSERT_NEXT(a_reset_queues, rst, empty && !full)
  `GFC_ASSERT_NEXT(a_result_holds, !rst && !empty && !pop, !empty && $stable({red, green, blue, alpha}))
  `GFC_ASSERT_NOW(a_count_reset, $past(rst) && !rst && psel && !pwrite && paddr == {REG_STOP_COUNT, 2'b00}, prdata == 32'd1)

endmodule

bind gradient_fill_color gfc_checker u_gfc_checker (.*);

`default_nettype wire

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import gfc_pkg::*;

  // colour expected back for one query
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pixel_t;

  localparam longint unsigned UNIT = 65536;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // input side, known from time zero
  logic               push = 1'b0;
  logic               kind = KIND_LOAD;
  logic [3:0]         stop_slot = '0;
  logic [7:0]         stop_ratio = '0;
  logic [31:0]        stop_color = '0;
  logic signed [23:0] point_x = '0;
  logic signed [23:0] point_y = '0;
  logic               full;

  // result side
  logic               empty;
  logic               pop = 1'b0;
  logic [7:0]         red, green, blue, alpha;

  // register port
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  gradient_fill_color DUT (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .kind(kind), .stop_slot(stop_slot),
    .stop_ratio(stop_ratio), .stop_color(stop_color),
    .point_x(point_x), .point_y(point_y),
    .empty(empty), .pop(pop), .red(red), .green(green), .blue(blue), .alpha(alpha),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // testbench copy of the block's registers and stop table
  logic [1:0]        mode_now = MODE_LINEAR;
  logic signed [9:0] focal_now = '0;
  logic [4:0]        count_now = 5'd1;
  logic [39:0]       stops [MAX_STOPS];

  item_t  pending_items[$];   // waiting to be driven
  pixel_t pixels_due[$];      // predicted colours, oldest first
  item_t  on_bus;
  int     send_gap = 0;
  int     pop_hold = 0;
  bit     no_idle = 1'b0;
  bit     failed = 1'b0;

  function automatic int draw_wait();
    return no_idle ? 0 : $urandom_range(0, 7);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r = 0;
    longint unsigned b = 64'h4000_0000_0000_0000;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // 1/t of the farther root for the ray from the focal point
  function automatic longint unsigned focal_position(longint x, longint y);
    longint f, dx, dy, d;
    longint unsigned a, n, s;
    f = focal_now;
    if (f > 256) f = 256;
    if (f < -256) f = -256;
    dx = x - 16384 * f;
    dy = y;
    if (dx == 0 && dy == 0) return 0;   // zero-length ray
    if (dx >= (64'sd1 <<< 23) || -dx >= (64'sd1 <<< 23) ||
        dy >= (64'sd1 <<< 23) || -dy >= (64'sd1 <<< 23)) return UNIT;
    a = longint'(dx * dx) + longint'(dy * dy);
    n = a * 65536 - longint'(f * f) * longint'(dy * dy);
    s = int_sqrt(n);
    d = longint'(s) - f * dx;
    if (d <= 0 || 4 * a >= longint'(d) * UNIT) return UNIT;
    return (4 * a) / longint'(d);
  endfunction

  function automatic longint unsigned gradient_position(logic signed [23:0] px,
                                                        logic signed [23:0] py);
    longint x, y, t;
    longint unsigned p;
    x = px;
    y = py;
    case (mode_now)
      MODE_LINEAR: begin
        t = x + 4194304;
        if (t <= 0) return 0;
        p = t >> 7;
        return (p > UNIT) ? UNIT : p;
      end
      MODE_RADIAL: begin
        p = int_sqrt((longint'(x * x) + longint'(y * y)) >> 12);
        return (p > UNIT) ? UNIT : p;
      end
      MODE_FOCAL: return focal_position(x, y);
      default: return 0;
    endcase
  endfunction

  function automatic pixel_t gradient_pixel(item_t q);
    longint unsigned pos, num, den, lr, rr, ratio, l, r;
    logic [31:0] lcol, rcol;
    int n;
    logic [7:0] ch [4];
    pos = gradient_position(q.point_x, q.point_y);
    n = count_now;
    if (n == 0) n = 1;
    if (n > MAX_STOPS) n = MAX_STOPS;
    lcol = stops[0][31:0];
    rcol = stops[n-1][31:0];
    lr = 0;
    rr = 255;
    for (int i = 0; i < n; i++) begin
      ratio = stops[i][39:32];
      if (pos * 255 < ratio * 65536) begin
        rcol = stops[i][31:0];
        rr = ratio;
        break;
      end
      lcol = stops[i][31:0];
      lr = ratio;
    end
    // equal ratios collapse onto the left colour
    if (rr <= lr || pos * 255 < lr * 65536) begin
      num = 0;
      den = 1;
    end else begin
      num = pos * 255 - lr * 65536;
      den = (rr - lr) * 65536;
      if (num > den) num = den;
    end
    for (int c = 0; c < 4; c++) begin
      l = lcol[8*c +: 8];
      r = rcol[8*c +: 8];
      ch[c] = 8'((l * (den - num) + r * num + den / 2) / den);
    end
    return '{red: ch[0], green: ch[1], blue: ch[2], alpha: ch[3]};
  endfunction

  // driver: one item on the bus at a time, random gaps between transfers
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        if (on_bus.kind == KIND_LOAD) stops[on_bus.stop_slot] = {on_bus.stop_ratio,
                                                                  on_bus.stop_color};
        else pixels_due = {pixels_due, gradient_pixel(on_bus)};
        send_gap = draw_wait();
      end
      if (!(push && full)) begin
        if (send_gap > 0) begin
          send_gap--;
          push <= 1'b0;
        end else if (pending_items.size() > 0) begin
          on_bus = pending_items.pop_front();
          kind <= on_bus.kind;
          stop_slot <= on_bus.stop_slot;
          stop_ratio <= on_bus.stop_ratio;
          stop_color <= on_bus.stop_color;
          point_x <= on_bus.point_x;
          point_y <= on_bus.point_y;
          push <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // monitor: check each result transfer against the oldest prediction
  always @(posedge clk) begin
    pixel_t want;
    if (rst) begin
      pop <= 1'b0;
    end else if (pop && !empty) begin
      if (pixels_due.size() == 0) begin
        $display("%0t: result with nothing expected: %h %h %h %h",
                 $time, red, green, blue, alpha);
        failed = 1'b1;
      end else begin
        want = pixels_due.pop_front();
        if (red !== want.red) begin
          $display("%0t: red expected %h actual %h", $time, want.red, red);
          failed = 1'b1;
        end
        if (green !== want.green) begin
          $display("%0t: green expected %h actual %h", $time, want.green, green);
          failed = 1'b1;
        end
        if (blue !== want.blue) begin
          $display("%0t: blue expected %h actual %h", $time, want.blue, blue);
          failed = 1'b1;
        end
        if (alpha !== want.alpha) begin
          $display("%0t: alpha expected %h actual %h", $time, want.alpha, alpha);
          failed = 1'b1;
        end
      end
      pop_hold = draw_wait();
      pop <= (pop_hold == 0);
    end else if (!pop) begin
      if (pop_hold > 0) pop_hold--;
      if (pop_hold == 0) pop <= 1'b1;
    end
  end

  // wait for every transfer to finish, then for the back end to go quiet
  task automatic settle();
    while (pending_items.size() != 0 || push || pixels_due.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // setup cycle, access cycle, register written at the following edge
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_FILL_MODE:    mode_now = val[1:0];
      REG_FOCAL_OFFSET: focal_now = val[9:0];
      default:          count_now = val[4:0];
    endcase
  endtask

  task automatic configure(logic [1:0] m, logic [9:0] f, logic [4:0] n);
    settle();
    write_reg(REG_FILL_MODE, 32'(m));
    write_reg(REG_FOCAL_OFFSET, 32'(f));
    write_reg(REG_STOP_COUNT, 32'(n));
    no_idle = ($urandom_range(0, 3) == 0);
  endtask

  task automatic add_load(logic [3:0] slot, logic [7:0] ratio, logic [31:0] color);
    item_t it;
    it = '0;
    it.kind = KIND_LOAD;
    it.stop_slot = slot;
    it.stop_ratio = ratio;
    it.stop_color = color;
    it.point_x = 24'($urandom);
    it.point_y = 24'($urandom);
    pending_items = {pending_items, it};
  endtask

  task automatic add_query(logic signed [23:0] x, logic signed [23:0] y);
    item_t it;
    it = '0;
    it.kind = KIND_QUERY;
    it.stop_slot = 4'($urandom);
    it.stop_ratio = 8'($urandom);
    it.stop_color = $urandom;
    it.point_x = x;
    it.point_y = y;
    pending_items = {pending_items, it};
  endtask

  // coordinates spread over the gradient circle, the full range and the edges
  function automatic logic signed [23:0] any_coord(int center);
    case ($urandom_range(0, 5))
      0:       return 24'($urandom);
      1:       return $urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000;
      2:       return 24'(center + $signed($urandom_range(0, 64)) - 32);
      default: return 24'(center + $signed($urandom_range(0, 10000000)) - 5000000);
    endcase
  endfunction

  // ascending ratios with occasional repeats, or random ratios in any order
  task automatic load_table(bit ordered);
    int r;
    r = $urandom_range(0, 20);
    for (int i = 0; i < MAX_STOPS; i++) begin
      if (ordered) begin
        if ($urandom_range(0, 4) != 0) r += $urandom_range(1, 30);
        if (r > 255) r = 255;
        add_load(4'(i), 8'(r), $urandom);
      end else begin
        add_load(4'(i), 8'($urandom), $urandom);
      end
    end
  endtask

  initial begin
    int cx;
    logic signed [9:0] fo;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extreme ratios and colours, repeated ratios, every mode
    configure(MODE_LINEAR, 10'sd0, 5'd16);
    for (int i = 0; i < MAX_STOPS; i++)
      add_load(4'(i), (i < 2) ? 8'd0 : (i > 13) ? 8'd255 : 8'(i * 18),
               (i % 2) ? 32'hffff_ffff : 32'h0000_0000);
    add_load(4'd5, 8'd90, 32'h1234_5678);   // equal ratios at slots 5 and 6
    add_load(4'd6, 8'd90, 32'hff00_ff00);
    add_query(24'sh800000, 24'sh7fffff);
    add_query(24'sh7fffff, 24'sh800000);
    add_query(24'sd0, 24'sd0);
    add_query(-24'sd4194304, 24'sd0);
    add_query(24'sd4194304, 24'sd0);
    add_query(24'sd1000000, 24'sd0);
    configure(MODE_RADIAL, 10'sd0, 5'd16);
    add_query(24'sd0, 24'sd0);
    add_query(24'sh7fffff, 24'sh7fffff);
    add_query(24'sd4194304, 24'sd0);
    add_query(24'sd1500000, -24'sd2000000);
    configure(MODE_FOCAL, 10'sd256, 5'd16);
    add_query(24'sd4194304, 24'sd0);        // point on the focal point
    add_query(24'sh800000, 24'sd0);
    add_query(24'sd0, 24'sh7fffff);
    configure(MODE_FOCAL, -10'sd512, 5'd16);  // saturates to -1.0
    add_query(-24'sd4194304, 24'sd0);
    add_query(24'sd100000, 24'sd300000);
    configure(MODE_NONE, 10'sd511, 5'd0);
    add_query(24'sd1234567, 24'sd7654321);
    configure(MODE_LINEAR, 10'sd0, 5'd31);
    add_query(24'sd3000000, 24'sd0);

    // random phases with fresh settings, edges included now and then
    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0:       fo = 10'sd256;
        1:       fo = -10'sd256;
        default: fo = 10'($urandom);
      endcase
      configure(2'($urandom), fo, (ph % 5 == 0) ? 5'd16 : (ph % 5 == 1) ? 5'd1 :
                5'($urandom));
      load_table($urandom_range(0, 4) != 0);
      cx = (fo > 256) ? 256 * 16384 : (fo < -256) ? -256 * 16384 : fo * 16384;
      if (mode_now != MODE_FOCAL) cx = 0;
      for (int k = 0; k < 80; k++) begin
        if ($urandom_range(0, 9) == 0) add_load(4'($urandom), 8'($urandom), $urandom);
        else add_query(any_coord(cx), any_coord(0));
      end
    end

    settle();
    if (!failed) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+src
src/gfc_pkg.sv
src/gfc_ram.sv
src/gfc_front.sv
src/gfc_back.sv
src/gradient_fill_color.sv
src/gfc_checker.sv
dv/tb.sv
